// ----- hdl/uf16_pkg.sv -----
// ----------------------------------------------------------------------------
// uf16_pkg
// Shared types and constants for the 16-bit unsigned float codec.
// ----------------------------------------------------------------------------
package uf16_pkg;

  localparam int unsigned WordBits  = 16;
  localparam int unsigned ExpBits   = 5;
  localparam int unsigned MantBits  = WordBits - ExpBits;
  localparam int unsigned EffBits   = MantBits + 1;
  localparam int unsigned PlainBits = 42;
  localparam int unsigned ValueBits = 64;

  // Smallest value that takes the saturation path
  localparam logic [ValueBits-1:0] MaxValue = 64'h0000_03FF_C000_0000;
  localparam logic [WordBits-1:0]  MaxCode  = 16'hFFFF;

  typedef enum logic [0:0] {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [ValueBits-1:0] plain_value;
    logic [WordBits-1:0]  wire_bytes;
  } in_item_t;

  typedef struct packed {
    logic [WordBits-1:0]  wire_out;
    logic [PlainBits-1:0] plain_out;
    logic                 clamped;
  } out_item_t;

endpackage

// ----- hdl/uf16_if.sv -----
// ----------------------------------------------------------------------------
// uf16_if
// Valid/ready channels of the codec: input items, result items and the
// configuration write channel.
// ----------------------------------------------------------------------------
interface uf16_in_if;
  logic               valid;
  logic               ready;
  uf16_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface uf16_out_if;
  logic                valid;
  logic                ready;
  uf16_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface uf16_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/ufloat16_codec.sv -----
// ----------------------------------------------------------------------------
// ufloat16_codec
// Encodes 64-bit unsigned integers to 16-bit unsigned float wire words and
// decodes wire words back, one item per cycle unless the receiver stalls.
// ----------------------------------------------------------------------------
// Usage:
//   item   - input beats: op, plain_value (encode) or wire_bytes (decode).
//   result - one result beat per input beat, in order: wire_out for encode,
//            plain_out for decode, clamped when encode saturated.
//   cfg    - one-bit write of big_endian (1 = bytes swapped on the wire);
//            always ready, write it only while the codec is empty.
// An accepted input beat is held in the input register, then the
// conversion logic loads the result register. Throughput is one item per
// cycle while the receiver does not stall; the result register and the
// input register decouple the two sides, so a new beat is taken while a
// finished result still waits on the output.
// When the receiver stalls, the result register holds its beat and the
// input register takes one more; ready on item then drops until the
// result drains. Reset empties both registers and sets big_endian to 1.
// ----------------------------------------------------------------------------
module ufloat16_codec (
  input  logic       clk,
  input  logic       rst,
  uf16_in_if.sink    item,
  uf16_out_if.source result,
  uf16_cfg_if.sink   cfg
);

  logic                big_endian;
  logic                s1_valid;
  uf16_pkg::in_item_t  s1_item;
  logic                s2_valid;
  uf16_pkg::out_item_t s2_item;
  uf16_pkg::out_item_t s2_item_next;
  logic                s1_load;
  logic                s2_load;

  // Encode path signals
  logic [5:0]                     lead;
  logic [uf16_pkg::ExpBits-1:0]   enc_exp;
  logic [uf16_pkg::PlainBits-1:0] enc_shifted;
  logic [uf16_pkg::WordBits-1:0]  enc_code;
  logic                           enc_sat;

  // Decode path signals
  logic [uf16_pkg::WordBits-1:0]  dec_code;
  logic [uf16_pkg::ExpBits-1:0]   dec_shift;
  logic [uf16_pkg::PlainBits-1:0] dec_value;

  // Configuration register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      big_endian <= 1'b1;
    end else if (cfg.valid && cfg.ready) begin
      big_endian <= cfg.data;
    end
  end

  // Handshake: each register advances when its successor has room
  assign s2_load    = s1_valid && (!s2_valid || result.ready);
  assign item.ready = !s1_valid || s2_load;
  assign s1_load    = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= 1'b1;
      end else if (s2_load) begin
        s1_valid <= 1'b0;
      end
      if (s2_load) begin
        s2_valid <= 1'b1;
      end else if (result.ready) begin
        s2_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_item <= item.data;
    end
    if (s2_load) begin
      s2_item <= s2_item_next;
    end
  end

  // Encode: find the leading one and fold the shift into the exponent
  always_comb begin
    lead = 6'd0;
    for (int i = 0; i < uf16_pkg::PlainBits; i++) begin
      if (s1_item.plain_value[i]) begin
        lead = 6'(i);
      end
    end
  end

  assign enc_exp     = 5'(lead - 6'd11);
  assign enc_shifted = s1_item.plain_value[uf16_pkg::PlainBits-1:0] >> enc_exp;
  assign enc_sat     = (s1_item.plain_value >= uf16_pkg::MaxValue);

  always_comb begin
    if (s1_item.plain_value < 64'(1 << uf16_pkg::EffBits)) begin
      enc_code = s1_item.plain_value[uf16_pkg::WordBits-1:0];
    end else if (enc_sat) begin
      enc_code = uf16_pkg::MaxCode;
    end else begin
      enc_code = {5'(lead - 6'd10), enc_shifted[uf16_pkg::MantBits-1:0]};
    end
  end

  // Decode: restore the hidden bit and shift left
  assign dec_code  = big_endian ?
                     {s1_item.wire_bytes[7:0], s1_item.wire_bytes[15:8]} :
                     s1_item.wire_bytes;
  assign dec_shift = dec_code[uf16_pkg::WordBits-1:uf16_pkg::MantBits] - 5'd1;

  always_comb begin
    if (dec_code[uf16_pkg::WordBits-1:uf16_pkg::EffBits] == '0) begin
      dec_value = 42'(dec_code);
    end else begin
      dec_value = 42'({1'b1, dec_code[uf16_pkg::MantBits-1:0]}) << dec_shift;
    end
  end

  // Select the result fields by operation
  always_comb begin
    s2_item_next = '0;
    case (s1_item.op)
      uf16_pkg::OP_ENCODE: begin
        s2_item_next.wire_out = big_endian ?
                                {enc_code[7:0], enc_code[15:8]} : enc_code;
        s2_item_next.clamped  = enc_sat;
      end
      uf16_pkg::OP_DECODE: begin
        s2_item_next.plain_out = dec_value;
      end
      default: begin
        s2_item_next = '0;
      end
    endcase
  end

  assign result.valid = s2_valid;
  assign result.data  = s2_item;

endmodule
